// File: design/tcpa_pkg.sv
// ----------------------------------------------------------------------------
// TCP handshake RTT aggregator package
// Shared types, constants and register codes of the flow aggregator.
// ----------------------------------------------------------------------------
package tcpa_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int HOST_SLOTS_DEF  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int HOST_CNT_W = 3;
  localparam int SUM_W      = 47;

  // Configuration register indexes.
  localparam int REG_HOST_COUNT = 0;
  localparam int REG_HOST_A     = 1;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [31:0]      CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0]      DROP_MAX  = 16'hFFFF;
  localparam logic [47:0]      NEG_ONE48 = 48'hFFFF_FFFF_FFFF;

  // Input transaction payload, last field in the lowest bits.
  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] ack_rtt;
    logic [31:0] syn_rtt;
    logic [31:0] flow_dst_ip;
    logic [31:0] flow_src_ip;
    logic [15:0] flow_dst_port;
  } in_t;

  // Result transaction payload, last field in the lowest bits.
  typedef struct packed {
    logic [15:0]        dropped_records;
    logic [63:0]        last_stamp;
    logic [63:0]        first_stamp;
    logic signed [47:0] ack_rtt_total;
    logic signed [47:0] syn_rtt_total;
    logic [31:0]        record_count;
    logic [15:0]        out_dst_port;
    logic [31:0]        out_dst_ip;
    logic [31:0]        out_src_ip;
  } out_t;

  // One flow table entry.
  typedef struct packed {
    logic [15:0]      port;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [31:0]      count;
    logic [SUM_W-1:0] syn_sum;
    logic [SUM_W-1:0] ack_sum;
    logic [63:0]      first;
    logic [63:0]      last;
  } entry_t;

  // Operands of the shared saturating adder.
  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] lim;
  } add_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ADD_CNT,
    ST_ADD_SYN,
    ST_ADD_ACK,
    ST_WRITE,
    ST_DRAIN_RD,
    ST_DRAIN_LD
  } state_e;

endpackage

// File: design/tcpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/tcpa_sat_add.sv
// ----------------------------------------------------------------------------
// Shared saturating adder
// Adds two operands and clamps the sum at a selectable limit.
// ----------------------------------------------------------------------------
module tcpa_sat_add
  import tcpa_pkg::*;
(
  input  add_op_t          op_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [SUM_W:0] full;

  assign full  = {1'b0, op_i.a} + {1'b0, op_i.b};
  assign sum_o = (full > {1'b0, op_i.lim}) ? op_i.lim : full[SUM_W-1:0];

endmodule

// File: design/tcpa_host_match.sv
// ----------------------------------------------------------------------------
// Host address match
// Compares an IPv4 address against the enabled host address slots.
// ----------------------------------------------------------------------------
module tcpa_host_match
  import tcpa_pkg::*;
#(
  parameter int HOST_SLOTS = HOST_SLOTS_DEF
) (
  input  logic [31:0]                  ip_i,
  input  logic [HOST_CNT_W-1:0]        cnt_i,
  input  logic [HOST_SLOTS-1:0][31:0]  hosts_i,
  output logic                         hit_o
);

  always_comb begin
    hit_o = 1'b0;
    // A count above the slot number simply enables every slot.
    for (int s = 0; s < HOST_SLOTS; s++) begin
      if ((HOST_CNT_W'(s) < cnt_i) && (hosts_i[s] == ip_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

// File: design/tcp_handshake_rtt_flow_aggregator.sv
// ----------------------------------------------------------------------------
// TCP handshake RTT flow aggregator
// Groups handshake records by flow key in a table searched in allocation
// order, and drains every flow on the last record of a batch.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         tvalid/tready              tdata: record, tlast: batch end
//   m_axis    out        tvalid/tready              tdata: flow, tlast: last flow
//   cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// The key search reads one table entry per cycle from the single RAM read port,
// and a hit then runs count, SYN and ACK through one shared adder. A drain
// reads each flow in ST_DRAIN_RD and loads it into the result register in
// ST_DRAIN_LD, where it waits while the result is held by a low m_axis_tready.
// The table needs no clearing after reset; of the table state only the fill count is reset.
// The result register lets a new record be taken while the last flow waits.
module tcp_handshake_rtt_flow_aggregator
  import tcpa_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int HOST_SLOTS  = HOST_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // flow_dst_port, flow_src_ip, flow_dst_ip, syn_rtt, ack_rtt, stamp
  input  logic [207:0]          s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_src_ip, out_dst_ip, out_dst_port, record_count, syn_rtt_total,
  // ack_rtt_total, first_stamp, last_stamp, dropped_records
  output logic [351:0]          m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_e state_q, state_d;

  in_t                          in_q;
  logic                         in_last_q;
  logic [CW-1:0]                used_q, used_d;
  logic [15:0]                  drop_q, drop_d;
  logic [CW-1:0]                scan_q, scan_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]                cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]                wr_idx_q, wr_idx_d;
  logic [CW-1:0]                drain_q, drain_d;
  entry_t                       work_q, work_d;
  logic                         out_vld_q, out_vld_d;
  out_t                         out_q, out_d;
  logic [HOST_CNT_W-1:0]        host_cnt_q;
  logic [HOST_SLOTS-1:0][31:0]  host_q;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  entry_t                       ram_rdata;
  add_op_t                      add_op;
  logic [SUM_W-1:0]             add_sum;
  logic                         is_host;

  logic                         in_fire;
  logic                         key_hit;
  logic                         issue;
  logic                         scan_done;
  logic                         out_free;
  logic                         drain_last;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign key_hit   = cmp_vld_q
                     && (ram_rdata.port == in_q.flow_dst_port)
                     && (ram_rdata.src_ip == in_q.flow_src_ip)
                     && (ram_rdata.dst_ip == in_q.flow_dst_ip);
  assign issue     = (state_q == ST_SEARCH) && (scan_q < used_q) && !key_hit;
  // All entries read and the last compare came back without a match.
  assign scan_done = (scan_q == used_q) && !key_hit;
  assign out_free  = !out_vld_q || m_axis_tready;
  assign drain_last = (drain_q == (used_q - CW'(1)));

  tcpa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (work_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcpa_sat_add u_adder (
    .op_i  (add_op),
    .sum_o (add_sum)
  );

  tcpa_host_match #(
    .HOST_SLOTS (HOST_SLOTS)
  ) u_host (
    .ip_i    (ram_rdata.src_ip),
    .cnt_i   (host_cnt_q),
    .hosts_i (host_q),
    .hit_o   (is_host)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (key_hit) begin
          state_d = ST_ADD_CNT;
        end else if (scan_done) begin
          if (used_q < DEPTH_C) begin
            state_d = ST_WRITE;
          end else begin
            state_d = in_last_q ? ST_DRAIN_RD : ST_IDLE;
          end
        end
      end
      ST_ADD_CNT:  state_d = ST_ADD_SYN;
      ST_ADD_SYN:  state_d = ST_ADD_ACK;
      ST_ADD_ACK:  state_d = ST_WRITE;
      ST_WRITE:    state_d = in_last_q ? ST_DRAIN_RD : ST_IDLE;
      ST_DRAIN_RD: state_d = (used_q == '0) ? ST_IDLE : ST_DRAIN_LD;
      ST_DRAIN_LD: begin
        if (out_free) begin
          state_d = drain_last ? ST_IDLE : ST_DRAIN_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_q;
    ram_raddr     = scan_q[AW-1:0];
    add_op        = '0;
    used_d        = used_q;
    drop_d        = drop_q;
    scan_d        = scan_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    wr_idx_d      = wr_idx_q;
    drain_d       = drain_q;
    work_d        = work_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    out_d         = out_q;

    case (state_q)
      ST_IDLE: begin
        scan_d  = '0;
        drain_d = '0;
      end
      ST_SEARCH: begin
        cmp_vld_d = issue;
        cmp_idx_d = scan_q[AW-1:0];
        if (issue) begin
          scan_d = scan_q + CW'(1);
        end
        if (key_hit) begin
          work_d   = ram_rdata;
          wr_idx_d = cmp_idx_q;
        end else if (scan_done) begin
          if (used_q < DEPTH_C) begin
            work_d.port    = in_q.flow_dst_port;
            work_d.src_ip  = in_q.flow_src_ip;
            work_d.dst_ip  = in_q.flow_dst_ip;
            work_d.count   = 32'd1;
            work_d.syn_sum = SUM_W'(in_q.syn_rtt);
            work_d.ack_sum = SUM_W'(in_q.ack_rtt);
            work_d.first   = in_q.stamp;
            work_d.last    = in_q.stamp;
            wr_idx_d       = used_q[AW-1:0];
            used_d         = used_q + CW'(1);
          end else if (drop_q != DROP_MAX) begin
            drop_d = drop_q + 16'd1;
          end
        end
      end
      ST_ADD_CNT: begin
        add_op.a     = SUM_W'(work_q.count);
        add_op.b     = SUM_W'(1);
        add_op.lim   = SUM_W'(CNT_MAX);
        work_d.count = add_sum[31:0];
      end
      ST_ADD_SYN: begin
        add_op.a       = work_q.syn_sum;
        add_op.b       = SUM_W'(in_q.syn_rtt);
        add_op.lim     = SUM_MAX;
        work_d.syn_sum = add_sum;
      end
      ST_ADD_ACK: begin
        add_op.a       = work_q.ack_sum;
        add_op.b       = SUM_W'(in_q.ack_rtt);
        add_op.lim     = SUM_MAX;
        work_d.ack_sum = add_sum;
        work_d.last    = in_q.stamp;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      ST_DRAIN_RD: begin
        ram_raddr = drain_q[AW-1:0];
        if (used_q == '0) begin
          drop_d = '0;
        end
      end
      ST_DRAIN_LD: begin
        // Hold the read address so the read data stays put while stalled.
        ram_raddr = drain_q[AW-1:0];
        if (out_free) begin
          out_vld_d             = 1'b1;
          out_d.out_src_ip      = ram_rdata.src_ip;
          out_d.out_dst_ip      = ram_rdata.dst_ip;
          out_d.out_dst_port    = ram_rdata.port;
          out_d.record_count    = ram_rdata.count;
          out_d.syn_rtt_total   = is_host ? signed'({1'b0, ram_rdata.syn_sum})
                                          : signed'(NEG_ONE48);
          out_d.ack_rtt_total   = is_host ? signed'(NEG_ONE48)
                                          : signed'({1'b0, ram_rdata.ack_sum});
          out_d.first_stamp     = ram_rdata.first;
          out_d.last_stamp      = ram_rdata.last;
          out_d.dropped_records = drop_q;
          if (drain_last) begin
            used_d  = '0;
            drop_d  = '0;
            drain_d = '0;
          end else begin
            drain_d = drain_q + CW'(1);
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      drop_q       <= '0;
      scan_q       <= '0;
      cmp_vld_q    <= 1'b0;
      drain_q      <= '0;
      out_vld_q    <= 1'b0;
      m_axis_tlast <= 1'b0;
      host_cnt_q   <= '0;
      host_q       <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      drop_q    <= drop_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
      if ((state_q == ST_DRAIN_LD) && out_free) begin
        m_axis_tlast <= drain_last;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_HOST_COUNT)) begin
          host_cnt_q <= cfg_data_i[HOST_CNT_W-1:0];
        end
        for (int s = 0; s < HOST_SLOTS; s++) begin
          if (cfg_idx_i == CFG_IDX_W'(REG_HOST_A + s)) begin
            host_q[s] <= cfg_data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q      <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    cmp_idx_q <= cmp_idx_d;
    wr_idx_q  <= wr_idx_d;
    work_q    <= work_d;
    out_q     <= out_d;
  end

endmodule

// File: design/tcpa_checker.sv
// ----------------------------------------------------------------------------
// Flow aggregator port checker
// Watches the stream ports of the aggregator over time.
// ----------------------------------------------------------------------------
module tcpa_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [351:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  // Results are only produced by a drain, never from the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared outside a drain");

  // Exactly one of the two RTT totals is reported as minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[159] != m_axis_tdata[207]))
    else $error("RTT totals not exclusive");

endmodule

bind tcp_handshake_rtt_flow_aggregator tcpa_checker u_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow aggregator testbench
// Streams TCP handshake records into the aggregator and checks every drained
// flow, field by field, against a predictor of the flow table kept in the
// bench. A short scripted part covers extremes, host matching and register
// corner cases. Randomized batches follow, with full tables and drops. A short
// run on two flows at maximum RTT, with no idling, ends the test.
// ----------------------------------------------------------------------------
module tb_top
  import tcpa_pkg::*;
();

  localparam int TBL_DEPTH   = TABLE_DEPTH_DEF;
  localparam int SETTLE_CYC  = TABLE_DEPTH_DEF + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_RECS  = 48;
  // Record pairs in the closing run.
  localparam int SOAK_RECS   = 6;

  localparam int REG_HOST_B = REG_HOST_A + 1;
  localparam int REG_HOST_C = REG_HOST_A + 2;
  localparam int REG_HOST_D = REG_HOST_A + 3;
  localparam int REG_SPARE  = REG_HOST_A + 4;
  localparam int REG_TOP    = (1 << CFG_IDX_W) - 1;

  typedef struct {
    out_t data;
    logic tail;
  } flow_report_t;

  typedef enum logic {ROW_RECORD, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    in_t         rec;
    logic        tail;
    int          reg_idx;
    logic [31:0] reg_val;
    bit          typed;
    out_t        want;
  } plan_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [207:0]          s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [351:0]          m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Flow table and registers as the predictor sees them.
  entry_t          flow_slots [TBL_DEPTH];
  int              flows_open     = 0;
  logic [15:0]     drop_count     = '0;
  logic [2:0]      host_count_cfg = '0;
  logic [31:0]     host_ip_cfg [4] = '{default: '0};
  flow_report_t    expected_flows [$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit idle_en      = 1'b0;
  bit stall_en     = 1'b0;

  always #6 clk_i = ~clk_i;

  tcp_handshake_rtt_flow_aggregator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [31:0] inc);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W-31){1'b0}}, inc};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic bit is_host(logic [31:0] ip);
    int n;
    n = (host_count_cfg > HOST_SLOTS_DEF) ? HOST_SLOTS_DEF : int'(host_count_cfg);
    for (int i = 0; i < n; i++) begin
      if (host_ip_cfg[i] == ip) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_cfg(int idx, logic [31:0] val);
    if (idx == REG_HOST_COUNT) begin
      host_count_cfg = val[2:0];
    end else if (idx >= REG_HOST_A && idx <= REG_HOST_D) begin
      host_ip_cfg[idx - REG_HOST_A] = val;
    end
  endfunction

  function automatic void aggregate_record(in_t rec, logic tail);
    int           hit;
    flow_report_t rep;
    bit           host;
    hit = -1;
    for (int i = 0; i < flows_open; i++) begin
      if (flow_slots[i].port == rec.flow_dst_port && flow_slots[i].src_ip == rec.flow_src_ip &&
          flow_slots[i].dst_ip == rec.flow_dst_ip) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      if (flow_slots[hit].count != CNT_MAX) begin
        flow_slots[hit].count = flow_slots[hit].count + 32'd1;
      end
      flow_slots[hit].syn_sum = sat_sum(flow_slots[hit].syn_sum, rec.syn_rtt);
      flow_slots[hit].ack_sum = sat_sum(flow_slots[hit].ack_sum, rec.ack_rtt);
      flow_slots[hit].last    = rec.stamp;
    end else if (flows_open < TBL_DEPTH) begin
      flow_slots[flows_open].port    = rec.flow_dst_port;
      flow_slots[flows_open].src_ip  = rec.flow_src_ip;
      flow_slots[flows_open].dst_ip  = rec.flow_dst_ip;
      flow_slots[flows_open].count   = 32'd1;
      flow_slots[flows_open].syn_sum = {{(SUM_W-32){1'b0}}, rec.syn_rtt};
      flow_slots[flows_open].ack_sum = {{(SUM_W-32){1'b0}}, rec.ack_rtt};
      flow_slots[flows_open].first   = rec.stamp;
      flow_slots[flows_open].last    = rec.stamp;
      flows_open++;
    end else if (drop_count != DROP_MAX) begin
      drop_count = drop_count + 16'd1;
    end
    if (tail) begin
      for (int i = 0; i < flows_open; i++) begin
        host = is_host(flow_slots[i].src_ip);
        rep.data.out_src_ip      = flow_slots[i].src_ip;
        rep.data.out_dst_ip      = flow_slots[i].dst_ip;
        rep.data.out_dst_port    = flow_slots[i].port;
        rep.data.record_count    = flow_slots[i].count;
        rep.data.syn_rtt_total   = host ? {1'b0, flow_slots[i].syn_sum} : NEG_ONE48;
        rep.data.ack_rtt_total   = host ? NEG_ONE48 : {1'b0, flow_slots[i].ack_sum};
        rep.data.first_stamp     = flow_slots[i].first;
        rep.data.last_stamp      = flow_slots[i].last;
        rep.data.dropped_records = drop_count;
        rep.tail                 = (i == flows_open - 1);
        expected_flows.push_back(rep);
      end
      flows_open = 0;
      drop_count = '0;
    end
  endfunction

  // ----------------------------------------------------------------- checking

  function automatic void cmp_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", fname, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic check_flow();
    out_t         got;
    flow_report_t want;
    got = m_axis_tdata;
    if (expected_flows.size() == 0) begin
      $error("flow result with none pending: %0h", m_axis_tdata);
      mismatches++;
    end else begin
      want = expected_flows.pop_front();
      cmp_field("out_src_ip", want.data.out_src_ip, got.out_src_ip);
      cmp_field("out_dst_ip", want.data.out_dst_ip, got.out_dst_ip);
      cmp_field("out_dst_port", want.data.out_dst_port, got.out_dst_port);
      cmp_field("record_count", want.data.record_count, got.record_count);
      cmp_field("syn_rtt_total", want.data.syn_rtt_total, got.syn_rtt_total);
      cmp_field("ack_rtt_total", want.data.ack_rtt_total, got.ack_rtt_total);
      cmp_field("first_stamp", want.data.first_stamp, got.first_stamp);
      cmp_field("last_stamp", want.data.last_stamp, got.last_stamp);
      cmp_field("dropped_records", want.data.dropped_records, got.dropped_records);
      cmp_field("last_out", want.tail, m_axis_tlast);
    end
  endtask

  // Result side: check each transaction, then stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_flow();
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (stall_en && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_record(input in_t rec, input logic tail);
    s_axis_tdata  <= rec;
    s_axis_tlast  <= tail;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    aggregate_record(rec, tail);
  endtask

  task automatic maybe_gap();
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_flows_out();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_flows.size() != 0);
  endtask

  // A record that drains nothing may still be in the search when the last
  // flow leaves, so give the block time to go idle.
  task automatic settle();
    wait_flows_out();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    apply_cfg(idx, val);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] draw_src();
    if ($urandom_range(0, 1) == 0) return host_ip_cfg[$urandom_range(0, 3)];
    return pick32();
  endfunction

  function automatic in_t fresh_key();
    in_t k;
    k               = '0;
    k.flow_dst_port = 16'(pick32());
    k.flow_src_ip   = draw_src();
    k.flow_dst_ip   = pick32();
    return k;
  endfunction

  // A key close to another one: one field differs, often by a single bit.
  function automatic in_t near_key(in_t k);
    case ($urandom_range(0, 2))
      0:       k.flow_dst_port ^= 16'(1) << $urandom_range(0, 15);
      1:       k.flow_src_ip ^= 32'(1) << $urandom_range(0, 31);
      default: k.flow_dst_ip = ($urandom_range(0, 1) == 0) ?
                               k.flow_dst_ip ^ (32'(1) << $urandom_range(0, 31)) : pick32();
    endcase
    return k;
  endfunction

  function automatic in_t with_payload(in_t k);
    k.syn_rtt = pick32();
    k.ack_rtt = pick32();
    k.stamp   = pick64();
    return k;
  endfunction

  function automatic in_t mk_rec(logic [15:0] port, logic [31:0] sip, logic [31:0] dip,
                                 logic [31:0] syn, logic [31:0] ack, logic [63:0] stamp);
    in_t r;
    r.flow_dst_port = port;
    r.flow_src_ip   = sip;
    r.flow_dst_ip   = dip;
    r.syn_rtt       = syn;
    r.ack_rtt       = ack;
    r.stamp         = stamp;
    return r;
  endfunction

  function automatic out_t mk_flow(logic [31:0] sip, logic [31:0] dip, logic [15:0] port,
                                   logic [47:0] syn, logic [47:0] ack, logic [63:0] stamp);
    out_t f;
    f.out_src_ip      = sip;
    f.out_dst_ip      = dip;
    f.out_dst_port    = port;
    f.record_count    = 32'd1;
    f.syn_rtt_total   = syn;
    f.ack_rtt_total   = ack;
    f.first_stamp     = stamp;
    f.last_stamp      = stamp;
    f.dropped_records = '0;
    return f;
  endfunction

  function automatic plan_row_t rec_row(in_t rec, logic tail);
    plan_row_t row;
    row         = '{kind: ROW_RECORD, default: '0};
    row.kind    = ROW_RECORD;
    row.rec     = rec;
    row.tail    = tail;
    return row;
  endfunction

  function automatic plan_row_t typed_row(in_t rec, out_t want);
    plan_row_t row;
    row       = rec_row(rec, 1'b1);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(int idx, logic [31:0] val);
    plan_row_t row;
    row         = '{kind: ROW_CONFIG, default: '0};
    row.kind    = ROW_CONFIG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic run_directed();
    plan_row_t    rows [$];
    flow_report_t rep;
    bit           after_rec;
    after_rec = 1'b0;
    idle_en   = 1'b1;
    stall_en  = 1'b1;

    // Single flows straight after reset: no host configured, SYN reads -1.
    rows.push_back(typed_row(mk_rec('0, '0, '0, '0, '0, '0),
                             mk_flow('0, '0, '0, NEG_ONE48, 48'h0, '0)));
    rows.push_back(typed_row(mk_rec('1, '1, '1, '1, '1, '1),
                             mk_flow('1, '1, '1, NEG_ONE48, 48'h0000_FFFF_FFFF, '1)));
    // Hits on a known flow between misses.
    rows.push_back(rec_row(mk_rec(16'h1234, 32'h0A00_0001, 32'hC0A8_0001, 32'd100, 32'd200,
                                  64'd1000), 1'b0));
    rows.push_back(rec_row(mk_rec(16'h1234, 32'h0A00_0001, 32'hC0A8_0001, 32'd50, 32'd25,
                                  64'd1010), 1'b0));
    rows.push_back(rec_row(mk_rec(16'd80, 32'hC0A8_0002, 32'h0A00_0001, 32'd7, 32'd9,
                                  64'd1020), 1'b0));
    rows.push_back(rec_row(mk_rec(16'h1234, 32'h0A00_0001, 32'hC0A8_0001, 32'd1, 32'd1,
                                  64'd1030), 1'b1));
    // Two hosts valid; the spare indexes must not land in any host slot.
    rows.push_back(cfg_row(REG_HOST_COUNT, 32'd2));
    rows.push_back(cfg_row(REG_HOST_A, 32'h0A00_0001));
    rows.push_back(cfg_row(REG_HOST_B, 32'hC0A8_0002));
    rows.push_back(cfg_row(REG_HOST_C, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_HOST_D, 32'h0000_0000));
    rows.push_back(cfg_row(REG_SPARE, 32'h1234_5678));
    rows.push_back(cfg_row(REG_TOP, 32'h1234_5678));
    rows.push_back(typed_row(mk_rec(16'd443, 32'h0A00_0001, 32'h0808_0808, 32'd5, 32'd6, 64'd77),
                             mk_flow(32'h0A00_0001, 32'h0808_0808, 16'd443, 48'd5, NEG_ONE48,
                                     64'd77)));
    rows.push_back(rec_row(mk_rec(16'd22, 32'hC0A8_0002, 32'h0101_0101, 32'd3, 32'd4, 64'd90),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd22, 32'hFFFF_FFFF, 32'h0101_0101, 32'd3, 32'd4, 64'd91),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd22, 32'h1234_5678, 32'h0101_0101, 32'd3, 32'd4, 64'd92),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd443, 32'h0A00_0001, 32'h0808_0808, 32'd8, 32'd9, 64'd93),
                           1'b1));
    // A host count above the slot count acts as all four slots.
    rows.push_back(cfg_row(REG_HOST_COUNT, 32'hFFFF_FFFD));
    rows.push_back(rec_row(mk_rec(16'd22, 32'hFFFF_FFFF, 32'h0202_0202, 32'd1, 32'd2, 64'd5),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd22, 32'h0000_0000, 32'h0202_0202, 32'd1, 32'd2, 64'd6),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd22, 32'h1234_5678, 32'h0202_0202, 32'd1, 32'd2, 64'd7),
                           1'b0));
    rows.push_back(rec_row(mk_rec(16'd22, 32'hC0A8_0002, 32'h0202_0202, 32'd1, 32'd2, 64'd8),
                           1'b1));
    // Keys that differ from the first one in a single field, then a hit on the first key.
    rows.push_back(cfg_row(REG_HOST_COUNT, 32'd0));
    rows.push_back(rec_row(mk_rec(16'd7, 32'd1, 32'd2, 32'd10, 32'd20, 64'd1), 1'b0));
    rows.push_back(rec_row(mk_rec(16'd8, 32'd1, 32'd2, 32'd10, 32'd20, 64'd2), 1'b0));
    rows.push_back(rec_row(mk_rec(16'd7, 32'd3, 32'd2, 32'd10, 32'd20, 64'd3), 1'b0));
    rows.push_back(rec_row(mk_rec(16'd7, 32'd1, 32'd4, 32'd10, 32'd20, 64'd4), 1'b0));
    rows.push_back(rec_row(mk_rec(16'd7, 32'd1, 32'd2, '1, '1, 64'd5), 1'b1));

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CONFIG) begin
        if (after_rec) settle();
        cfg_write(rows[k].reg_idx, rows[k].reg_val);
        after_rec = 1'b0;
      end else begin
        maybe_gap();
        send_record(rows[k].rec, rows[k].tail);
        if (rows[k].typed) begin
          rep      = expected_flows.pop_back();
          rep.data = rows[k].want;
          expected_flows.push_back(rep);
        end
        after_rec = 1'b1;
      end
    end
  endtask

  task automatic random_config(input int phase);
    int          cnt;
    logic [31:0] val;
    case (phase)
      0:       cnt = 0;
      1:       cnt = HOST_SLOTS_DEF;
      2:       cnt = 7;
      default: cnt = $urandom_range(0, 7);
    endcase
    val = ($urandom & ~32'h7) | 32'(cnt);
    cfg_write(REG_HOST_COUNT, val);
    for (int s = REG_HOST_A; s <= REG_HOST_D; s++) cfg_write(s, pick32());
    cfg_write($urandom_range(REG_SPARE, REG_TOP), $urandom);
  endtask

  task automatic small_batch(inout int sent);
    in_t pool [6];
    in_t rec;
    int  n_keys;
    int  n_recs;
    idle_en  = ($urandom_range(0, 3) != 0);
    stall_en = ($urandom_range(0, 3) != 0);
    n_keys   = $urandom_range(1, 6);
    n_recs   = $urandom_range(1, 10);
    pool[0]  = fresh_key();
    for (int k = 1; k < n_keys; k++) begin
      pool[k] = ($urandom_range(0, 1) == 0) ? fresh_key() : near_key(pool[$urandom_range(0, k-1)]);
    end
    for (int r = 0; r < n_recs; r++) begin
      rec = with_payload(pool[$urandom_range(0, n_keys-1)]);
      maybe_gap();
      send_record(rec, r == n_recs - 1);
    end
    sent += n_recs;
    // Now and then hold the next batch back until this drain is complete.
    if ($urandom_range(0, 3) == 0) wait_flows_out();
  endtask

  // Fill all entries, add a few hits and drops, and close the batch with a
  // record that either hits or is itself dropped.
  task automatic full_batch(inout int sent);
    in_t keys [TBL_DEPTH];
    in_t base;
    in_t rec;
    int  extra;
    idle_en  = ($urandom_range(0, 1) == 0);
    stall_en = ($urandom_range(0, 1) == 0);
    base     = fresh_key();
    extra    = $urandom_range(1, 4);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      keys[i]               = base;
      keys[i].flow_dst_port = base.flow_dst_port ^ 16'(i);
      keys[i].flow_src_ip   = draw_src();
      keys[i].flow_dst_ip   = pick32();
      maybe_gap();
      send_record(with_payload(keys[i]), 1'b0);
    end
    for (int j = 0; j < extra; j++) begin
      rec               = base;
      rec.flow_dst_port = base.flow_dst_port ^ 16'(TBL_DEPTH + j);
      maybe_gap();
      send_record(with_payload(rec), 1'b0);
      maybe_gap();
      send_record(with_payload(keys[$urandom_range(0, TBL_DEPTH-1)]), 1'b0);
    end
    if ($urandom_range(0, 1) == 0) begin
      rec = keys[$urandom_range(0, TBL_DEPTH-1)];
    end else begin
      rec               = base;
      rec.flow_dst_port = base.flow_dst_port ^ 16'd200;
    end
    maybe_gap();
    send_record(with_payload(rec), 1'b1);
    sent += TBL_DEPTH + 2 * extra + 1;
  endtask

  task automatic run_random();
    int sent;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      random_config(phase);
      sent = 0;
      if (phase % 2 == 1) begin
        small_batch(sent);
        full_batch(sent);
      end
      while (sent < PHASE_RECS) small_batch(sent);
    end
  endtask

  // Two flows at maximum RTT, one from a host and one not, so that both
  // report shapes are seen on large sums. No idling here.
  task automatic run_soak();
    in_t key_h;
    in_t key_p;
    in_t rec;
    settle();
    idle_en           = 1'b0;
    stall_en          = 1'b0;
    key_h             = fresh_key();
    key_p             = key_h;
    key_p.flow_src_ip = ~key_h.flow_src_ip;
    cfg_write(REG_HOST_COUNT, 32'd1);
    cfg_write(REG_HOST_A, key_h.flow_src_ip);
    for (int k = 0; k < SOAK_RECS; k++) begin
      rec         = key_h;
      rec.syn_rtt = '1;
      rec.ack_rtt = '1;
      rec.stamp   = 64'(k);
      send_record(rec, 1'b0);
      rec             = key_p;
      rec.syn_rtt     = '1;
      rec.ack_rtt     = '1;
      rec.stamp       = ~64'(k);
      send_record(rec, k == SOAK_RECS - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    run_soak();
    settle();
    if (mismatches == 0 && expected_flows.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
